>>> hdl/sset_pkg.sv
package sset_pkg;

    localparam int CAPACITY     = 64;
    localparam int ELEMENT_BITS = 32;
    localparam int VALUE_BITS   = 32;
    localparam int COUNT_BITS   = $clog2(CAPACITY + 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic                  opcode;
        logic [VALUE_BITS-1:0] element_value;
    } t_sset_in;

    typedef struct packed {
        logic                  was_present;
        logic                  dropped_full;
        logic [COUNT_BITS-1:0] element_count;
    } t_sset_out;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cell_flags;

endpackage

>>> hdl/sorted_set_insert_lookup_core.sv
// sorted set core: keeps up to 64 distinct unsigned values in ascending order
// command channel: drive i_item and raise start; a transfer happens at a
// rising edge with start high and busy low
// opcode insert adds the value unless already held, query only tests it
// every accepted item gives exactly one result on o_result, marked by a
// one-cycle o_result_strobe in the cycle after the transfer
// a new item may be given every cycle while busy is low: all cells
// of the chain compare against the value in parallel and shift together
// the result carries presence, a drop flag for an insert of an absent value into a full set,
// and the element count after the item
// the receiver cannot stall: each result is marked by the strobe for one cycle only
// synchronous active-low reset empties the set at once; busy is high while
// reset is applied and low otherwise
module sorted_set_insert_lookup_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  sset_pkg::t_sset_in   i_item,
    output logic                 o_result_strobe,
    output sset_pkg::t_sset_out  o_result
);
    import sset_pkg::*;

    logic                    accept;
    logic [ELEMENT_BITS-1:0] value;
    t_cell_flags             flags  [CAPACITY];
    logic [ELEMENT_BITS-1:0] values [CAPACITY];
    logic [CAPACITY-1:0]     eq_vec;
    logic                    present;
    logic                    full;
    logic                    shift_en;

    logic [COUNT_BITS-1:0]   r_count;
    logic [COUNT_BITS-1:0]   n_count;
    logic                    r_strobe;
    t_sset_out               r_result;
    t_sset_out               n_result;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;
    assign value  = i_item.element_value[ELEMENT_BITS-1:0];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                    left_lt;
            logic [ELEMENT_BITS-1:0] left_value;
            logic                    occupied;

            if (gi == 0) begin : g_head
                assign left_lt    = 1'b1;
                assign left_value = value;
            end else begin : g_body
                assign left_lt    = flags[gi-1].lt;
                assign left_value = values[gi-1];
            end

            assign occupied   = r_count > COUNT_BITS'(gi);
            assign eq_vec[gi] = flags[gi].eq;

            sset_cell u_cell (
                .i_clk        (i_clk),
                .i_shift_en   (shift_en),
                .i_occupied   (occupied),
                .i_value      (value),
                .i_left_lt    (left_lt),
                .i_left_value (left_value),
                .o_flags      (flags[gi]),
                .o_value      (values[gi])
            );
        end
    endgenerate

    assign present  = |eq_vec;
    assign full     = r_count == COUNT_BITS'(CAPACITY);
    assign shift_en = accept && (i_item.opcode == OP_INSERT) && !present && !full;

    always_comb begin
        n_count = shift_en ? r_count + COUNT_BITS'(1) : r_count;
        n_result.was_present   = present;
        n_result.dropped_full  = accept && (i_item.opcode == OP_INSERT) && !present && full;
        n_result.element_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_result_strobe)
        else $error("result strobe missing after transfer");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_result_strobe)
        else $error("result strobe without transfer");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_BITS'(CAPACITY))
        else $error("element count above capacity");

    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.dropped_full)
            |-> (o_result.element_count == COUNT_BITS'(CAPACITY) && !o_result.was_present))
        else $error("drop reported while not full");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        shift_en |=> r_count == $past(r_count) + COUNT_BITS'(1))
        else $error("count did not advance on insert");

endmodule

>>> hdl/sset_cell.sv
module sset_cell (
    input  logic                             i_clk,
    input  logic                             i_shift_en,
    input  logic                             i_occupied,
    input  logic [sset_pkg::ELEMENT_BITS-1:0] i_value,
    input  logic                             i_left_lt,
    input  logic [sset_pkg::ELEMENT_BITS-1:0] i_left_value,
    output sset_pkg::t_cell_flags            o_flags,
    output logic [sset_pkg::ELEMENT_BITS-1:0] o_value
);
    import sset_pkg::*;

    logic [ELEMENT_BITS-1:0] r_value;
    logic [ELEMENT_BITS-1:0] n_value;

    always_comb begin
        o_flags.lt = i_occupied && (r_value < i_value);
        o_flags.eq = i_occupied && (r_value == i_value);
    end

    // hold if smaller, take the new value at the insertion point, else shift up
    always_comb begin
        if (o_flags.lt) begin
            n_value = r_value;
        end else if (i_left_lt) begin
            n_value = i_value;
        end else begin
            n_value = i_left_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift_en) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule
